[hw/rtl/llf_pkg.sv]
`default_nettype none

package llf_pkg;

  // data and coefficient formats
  localparam int DATA_WIDTH     = 32;
  localparam int COEF_FRAC_BITS = 24;

  // register widths, fixed by the register map
  localparam int COEF_LAG_W  = 25;
  localparam int COEF_LEAD_W = 32;
  localparam int CLAMP_W     = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  // derived datapath widths
  localparam int DIFF_W      = DATA_WIDTH + 1;
  localparam int LEAD_PROD_W = COEF_LEAD_W + DIFF_W;
  localparam int LEAD_RAW_W  = LEAD_PROD_W - COEF_FRAC_BITS;
  localparam int LAG_COEF_W  = COEF_LAG_W + 1;
  localparam int LAG_PROD_W  = LAG_COEF_W + DIFF_W;
  localparam int LAG_RAW_W   = LAG_PROD_W - COEF_FRAC_BITS;
  localparam int WIDE_W      = (LEAD_RAW_W > CLAMP_W) ? LEAD_RAW_W : CLAMP_W;
  localparam int SUM_W       = ((LAG_RAW_W > DATA_WIDTH) ? LAG_RAW_W : DATA_WIDTH) + 2;

  // stream widths, whole bytes
  localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MIN  = 2'd3;

  // reset values
  localparam logic [COEF_LAG_W-1:0] COEF_LAG_RESET =
    COEF_LAG_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [COEF_LEAD_W-1:0] COEF_LEAD_RESET =
    COEF_LEAD_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [CLAMP_W-1:0] LEAD_MAX_RESET = {1'b0, {(CLAMP_W-1){1'b1}}};
  localparam logic signed [CLAMP_W-1:0] LEAD_MIN_RESET = {1'b1, {(CLAMP_W-1){1'b0}}};

  // data range limits
  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic        [COEF_LAG_W-1:0]  coef_lag;
    logic signed [COEF_LEAD_W-1:0] coef_lead;
    logic signed [CLAMP_W-1:0]     lead_max;
    logic signed [CLAMP_W-1:0]     lead_min;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] filtered;
    logic signed [DATA_WIDTH-1:0] lead_term;
    logic                         clamped;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/exponential_lead_lag_filter_core.sv]
// path: an accepted input beat passes the input register, then the output register, to its result beat
// throughput: one beat per cycle unless stalled; the state update (two multiplies, add, saturate)
//   is combinational from the input register to the state and output registers
// reset (rst, synchronous): previous sample and filter state cleared, pipeline emptied,
//   coefficients and lead clamps back to their defaults
`default_nettype none

module exponential_lead_lag_filter_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [llf_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] sample
  input  wire logic                               s_tuser,   // [0] restart
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [llf_pkg::OUT_TDATA_W-1:0]         m_tdata,   // [31:0] filtered, [63:32] lead_term
  output logic                                    m_tuser,   // [0] clamped
  // configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [llf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [llf_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DW = llf_pkg::DATA_WIDTH;

  llf_pkg::cfg_t cfg;
  llf_pkg::res_t res;

  // input register
  logic                 stage_valid;
  logic signed [DW-1:0] stage_sample;
  logic                 stage_restart;

  // filter history
  logic signed [DW-1:0] prev_sample;
  logic signed [DW-1:0] filter_state;

  // output register
  logic signed [DW-1:0] out_filtered;
  logic signed [DW-1:0] out_lead;
  logic                 out_clamped;

  logic advance;
  logic in_beat;

  llf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  llf_step u_step (
    .cfg          (cfg),
    .sample       (stage_sample),
    .restart      (stage_restart),
    .prev_sample  (prev_sample),
    .filter_state (filter_state),
    .res          (res)
  );

  // the staged beat moves on when the output register is free or being drained
  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;
  assign in_beat  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_beat) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      stage_sample  <= s_tdata[DW-1:0];
      stage_restart <= s_tuser;
    end
  end

  // history updates only when a beat is committed to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample  <= '0;
      filter_state <= '0;
    end else if (advance) begin
      prev_sample  <= stage_sample;
      filter_state <= res.filtered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_filtered <= res.filtered;
      out_lead     <= res.lead_term;
      out_clamped  <= res.clamped;
    end
  end

  assign m_tdata = llf_pkg::OUT_TDATA_W'({out_lead, out_filtered});
  assign m_tuser = out_clamped;

  // the shown result is always the current filter state
  a_out_is_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_filtered == filter_state))
    else $error("output beat differs from filter state");

  // a committed beat shows up on the output next cycle
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("committed beat missing on output");

  // a staged beat is kept while the output is stalled
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && m_tvalid && !m_tready) |=> (stage_valid && $stable(stage_sample)))
    else $error("staged beat lost under output stall");

endmodule

`default_nettype wire

[hw/rtl/llf_cfg_regs.sv]
`default_nettype none

module llf_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [llf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [llf_pkg::CFG_W-1:0]      cfg_data,
  output llf_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_lag  <= llf_pkg::COEF_LAG_RESET;
      cfg.coef_lead <= llf_pkg::COEF_LEAD_RESET;
      cfg.lead_max  <= llf_pkg::LEAD_MAX_RESET;
      cfg.lead_min  <= llf_pkg::LEAD_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        llf_pkg::REG_COEF_LAG:  cfg.coef_lag  <= cfg_data[llf_pkg::COEF_LAG_W-1:0];
        llf_pkg::REG_COEF_LEAD: cfg.coef_lead <= cfg_data[llf_pkg::COEF_LEAD_W-1:0];
        llf_pkg::REG_LEAD_MAX:  cfg.lead_max  <= cfg_data[llf_pkg::CLAMP_W-1:0];
        llf_pkg::REG_LEAD_MIN:  cfg.lead_min  <= cfg_data[llf_pkg::CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/llf_step.sv]
`default_nettype none

module llf_step (
  input  wire llf_pkg::cfg_t                         cfg,
  input  wire logic signed [llf_pkg::DATA_WIDTH-1:0] sample,
  input  wire logic                                  restart,
  input  wire logic signed [llf_pkg::DATA_WIDTH-1:0] prev_sample,
  input  wire logic signed [llf_pkg::DATA_WIDTH-1:0] filter_state,
  output llf_pkg::res_t                              res
);

  localparam int DW = llf_pkg::DATA_WIDTH;
  localparam int CF = llf_pkg::COEF_FRAC_BITS;

  logic signed [DW-1:0]                   prev_eff;
  logic signed [DW-1:0]                   state_eff;
  logic signed [llf_pkg::DIFF_W-1:0]      lead_diff;
  logic signed [llf_pkg::DIFF_W-1:0]      lag_diff;
  logic signed [llf_pkg::LEAD_PROD_W-1:0] lead_prod;
  logic signed [llf_pkg::LEAD_RAW_W-1:0]  lead_raw;
  logic signed [llf_pkg::LAG_COEF_W-1:0]  lag_coef;
  logic signed [llf_pkg::LAG_PROD_W-1:0]  lag_prod;
  logic signed [llf_pkg::LAG_RAW_W-1:0]   lag_raw;
  logic signed [llf_pkg::WIDE_W-1:0]      lead_w;
  logic signed [llf_pkg::WIDE_W-1:0]      lead_max_w;
  logic signed [llf_pkg::WIDE_W-1:0]      lead_min_w;
  logic signed [llf_pkg::WIDE_W-1:0]      lead_hi;
  logic signed [llf_pkg::WIDE_W-1:0]      lead_lim;
  logic                                   lead_ovf;
  logic signed [DW-1:0]                   lead;
  logic signed [llf_pkg::SUM_W-1:0]       sum;
  logic                                   sum_ovf;

  // restart loads both history registers with the sample first
  assign prev_eff  = restart ? sample : prev_sample;
  assign state_eff = restart ? sample : filter_state;

  assign lead_diff = llf_pkg::DIFF_W'(sample) - llf_pkg::DIFF_W'(prev_eff);
  assign lag_diff  = llf_pkg::DIFF_W'(prev_eff) - llf_pkg::DIFF_W'(state_eff);

  // products dropped to the data format by arithmetic shift (floor)
  assign lead_prod = cfg.coef_lead * lead_diff;
  assign lead_raw  = lead_prod[llf_pkg::LEAD_PROD_W-1:CF];
  assign lag_coef  = {1'b0, cfg.coef_lag};
  assign lag_prod  = lag_coef * lag_diff;
  assign lag_raw   = lag_prod[llf_pkg::LAG_PROD_W-1:CF];

  // max first, then min, so min wins when the limits cross
  assign lead_w     = llf_pkg::WIDE_W'(lead_raw);
  assign lead_max_w = llf_pkg::WIDE_W'(cfg.lead_max);
  assign lead_min_w = llf_pkg::WIDE_W'(cfg.lead_min);
  assign lead_hi    = (lead_w > lead_max_w) ? lead_max_w : lead_w;
  assign lead_lim   = (lead_hi < lead_min_w) ? lead_min_w : lead_hi;
  assign lead_ovf   = llf_pkg::WIDE_W'($signed(lead_lim[DW-1:0])) != lead_lim;

  always_comb begin
    if (lead_ovf) begin
      lead = lead_lim[llf_pkg::WIDE_W-1] ? llf_pkg::DATA_MIN : llf_pkg::DATA_MAX;
    end else begin
      lead = lead_lim[DW-1:0];
    end
  end

  assign sum = llf_pkg::SUM_W'(state_eff) + llf_pkg::SUM_W'(lag_raw)
             + llf_pkg::SUM_W'(lead);
  assign sum_ovf = llf_pkg::SUM_W'($signed(sum[DW-1:0])) != sum;

  always_comb begin
    if (sum_ovf) begin
      res.filtered = sum[llf_pkg::SUM_W-1] ? llf_pkg::DATA_MIN : llf_pkg::DATA_MAX;
    end else begin
      res.filtered = sum[DW-1:0];
    end
    res.lead_term = lead;
    res.clamped   = sum_ovf || (llf_pkg::WIDE_W'(lead) != lead_w);
  end

endmodule

`default_nettype wire

[verif/exponential_lead_lag_filter_core_tb.sv]
`timescale 1ns / 1ps

module exponential_lead_lag_filter_core_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 195;
  localparam int DW           = llf_pkg::DATA_WIDTH;
  localparam int CW           = llf_pkg::CFG_W;
  localparam int LW           = llf_pkg::COEF_LAG_W;

  // tracks the filter state and config, predicts every result beat, checks in order
  class filter_scoreboard;
    logic        [llf_pkg::COEF_LAG_W-1:0]  coef_lag;
    logic signed [llf_pkg::COEF_LEAD_W-1:0] coef_lead;
    logic signed [llf_pkg::CLAMP_W-1:0]     lead_max;
    logic signed [llf_pkg::CLAMP_W-1:0]     lead_min;
    logic signed [llf_pkg::DATA_WIDTH-1:0]  prev_sample;
    logic signed [llf_pkg::DATA_WIDTH-1:0]  state;
    llf_pkg::res_t expected_results[$];
    int   errors;
    int   results_seen;

    function new();
      coef_lag    = llf_pkg::COEF_LAG_RESET;
      coef_lead   = llf_pkg::COEF_LEAD_RESET;
      lead_max    = llf_pkg::LEAD_MAX_RESET;
      lead_min    = llf_pkg::LEAD_MIN_RESET;
      prev_sample = '0;
      state       = '0;
      errors      = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void set_reg(logic [llf_pkg::CFG_IDX_W-1:0] idx,
                          logic [llf_pkg::CFG_W-1:0] data);
      case (idx)
        llf_pkg::REG_COEF_LAG:  coef_lag  = data[llf_pkg::COEF_LAG_W-1:0];
        llf_pkg::REG_COEF_LEAD: coef_lead = data;
        llf_pkg::REG_LEAD_MAX:  lead_max  = data;
        llf_pkg::REG_LEAD_MIN:  lead_min  = data;
        default: ;
      endcase
    endfunction

    // one accepted input beat -> one expected result
    function void note_sample(logic signed [llf_pkg::DATA_WIDTH-1:0] sample, logic restart);
      logic signed [95:0] s_w, p_w, f_w, c_lead, c_lag, raw, lead, lag_inc, next_w;
      llf_pkg::res_t r;
      if (restart) begin
        prev_sample = sample;
        state       = sample;
      end
      s_w    = sample;
      p_w    = prev_sample;
      f_w    = state;
      c_lead = coef_lead;
      c_lag  = $signed({1'b0, coef_lag});
      // products floor toward minus infinity
      raw  = (c_lead * (s_w - p_w)) >>> llf_pkg::COEF_FRAC_BITS;
      lead = raw;
      if (lead > lead_max) lead = lead_max;
      // crossed clamps: the lower bound wins
      if (lead < lead_min) lead = lead_min;
      // clamps are 32 bits, so lead already sits in the data range
      r.clamped = (lead != raw);
      lag_inc = (c_lag * (p_w - f_w)) >>> llf_pkg::COEF_FRAC_BITS;
      next_w  = f_w + lag_inc + lead;
      if (next_w > llf_pkg::DATA_MAX) begin
        next_w = llf_pkg::DATA_MAX;
        r.clamped = 1'b1;
      end
      if (next_w < llf_pkg::DATA_MIN) begin
        next_w = llf_pkg::DATA_MIN;
        r.clamped = 1'b1;
      end
      state       = next_w[llf_pkg::DATA_WIDTH-1:0];
      prev_sample = sample;
      r.filtered  = state;
      r.lead_term = lead[llf_pkg::DATA_WIDTH-1:0];
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(llf_pkg::res_t got);
      llf_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", results_seen));
        results_seen++;
        return;
      end
      want = expected_results.pop_front();
      if (got.filtered !== want.filtered)
        report($sformatf("beat %0d filtered %h, want %h",
                         results_seen, got.filtered, want.filtered));
      if (got.lead_term !== want.lead_term)
        report($sformatf("beat %0d lead_term %h, want %h",
                         results_seen, got.lead_term, want.lead_term));
      if (got.clamped !== want.clamped)
        report($sformatf("beat %0d clamped %b, want %b",
                         results_seen, got.clamped, want.clamped));
      results_seen++;
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [llf_pkg::IN_TDATA_W-1:0]  s_tdata;   // [31:0] sample
  logic                            s_tuser;   // [0] restart
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [llf_pkg::OUT_TDATA_W-1:0] m_tdata;   // [31:0] filtered, [63:32] lead_term
  logic                            m_tuser;   // [0] clamped
  logic                            cfg_we;
  logic [llf_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [llf_pkg::CFG_W-1:0]       cfg_data;

  filter_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left  = 0;
  int ready_run   = 0;
  int ready_mode  = 0;

  exponential_lead_lag_filter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL exponential_lead_lag_filter_core");
      $finish;
    end
  end

  // input beats feed the predictor, result beats get checked
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_sample(s_tdata[DW-1:0], s_tuser);
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{filtered:  m_tdata[DW-1:0],
                        lead_term: m_tdata[2*DW-1:DW],
                        clamped:   m_tuser});
  end

  // receiver backpressure: stretches of stall, of full speed, and of dithering
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_run  = (ready_mode == 0) ? $urandom_range(1, 8) : $urandom_range(1, 40);
    end
    ready_run--;
    case (ready_mode)
      0:       m_tready <= 1'b0;
      3:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= 1'b1;
    endcase
  end

  // hold the beat until the handshake, leave at the falling edge
  task automatic send_beat(input logic [DW-1:0] sample, input logic restart);
    s_tvalid = 1'b1;
    s_tdata  = sample;
    s_tuser  = restart;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // sender runs in bursts with random gaps between them
  task automatic feed(input logic [DW-1:0] sample, input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_beat(sample, restart);
  endtask

  // stop sending until every expected result is back, then let the pipe settle
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [llf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_config(input logic [CW-1:0] lag, input logic [CW-1:0] lead,
                              input logic [CW-1:0] hi, input logic [CW-1:0] lo);
    wait_idle();
    write_reg(llf_pkg::REG_COEF_LAG, lag);
    write_reg(llf_pkg::REG_COEF_LEAD, lead);
    write_reg(llf_pkg::REG_LEAD_MAX, hi);
    write_reg(llf_pkg::REG_LEAD_MIN, lo);
  endtask

  // mostly a drifting signal, with occasional jumps and rail values
  function automatic logic [DW-1:0] pick_sample(input logic signed [DW-1:0] last);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll < 2) return $urandom;
    if (roll == 2) begin
      case ($urandom_range(0, 3))
        0:       return llf_pkg::DATA_MAX;
        1:       return llf_pkg::DATA_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (roll < 11) return last + ($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  // upper bits above the 25-bit register carry junk that must be dropped
  function automatic logic [CW-1:0] pick_lag();
    logic [CW-1:0] junk;
    junk = $urandom;
    case ($urandom_range(0, 5))
      0:       return {junk[CW-1:LW], LW'(0)};
      1:       return {junk[CW-1:LW], llf_pkg::COEF_LAG_RESET};
      2:       return {junk[CW-1:LW], {LW{1'b1}}};
      3:       return {junk[CW-1:LW], LW'($urandom)};
      default: return {junk[CW-1:LW], LW'($urandom_range(0, 1 << 24))};
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_lead();
    case ($urandom_range(0, 6))
      0:       return llf_pkg::COEF_LEAD_RESET;
      1:       return {1'b0, {(CW-1){1'b1}}};
      2:       return {1'b1, {(CW-1){1'b0}}};
      3:       return $urandom;
      default: return $signed($urandom_range(0, 1 << 27)) - (1 << 26);
    endcase
  endfunction

  initial begin
    logic signed [DW-1:0] last;
    logic signed [CW-1:0] hi, lo, width;
    logic                 restart;
    int                   ph, n;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = llf_pkg::REG_COEF_LAG;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: rails, lead clamp at the low limit, restart to each rail
    feed(32'h0000_0000, 1'b0);
    feed(32'h7fff_ffff, 1'b0);
    feed(32'h8000_0000, 1'b0);
    feed(32'h8000_0000, 1'b1);
    feed(32'h7fff_ffff, 1'b0);
    feed(32'h7fff_ffff, 1'b1);
    feed(32'h0001_0000, 1'b0);

    // lag above one, steepest positive lead, narrow clamps; drives the state into saturation
    apply_config(CW'({LW{1'b1}}), 32'h7fff_ffff, 32'h0010_0000, 32'hfff0_0000);
    feed(32'h0001_0000, 1'b1);
    feed(32'h7fff_ffff, 1'b0);
    feed(32'h8000_0000, 1'b0);
    feed(32'h0000_0000, 1'b0);
    feed(32'hffff_ffff, 1'b0);

    // lag of zero adds no lag term, most negative lead, crossed clamps
    apply_config(32'h0000_0000, 32'h8000_0000, 32'hffff_0000, 32'h0001_0000);
    feed(32'h1234_5678, 1'b1);
    feed(32'h1234_5679, 1'b0);
    feed(32'h0000_0000, 1'b0);
    feed(32'hffff_0000, 1'b0);

    // zero lead with clamps pinned at zero, unity lag
    apply_config({7'h55, llf_pkg::COEF_LAG_RESET}, 32'h0000_0000, 32'h0000_0000,
                 32'h0000_0000);
    feed(32'h7fff_ffff, 1'b1);
    feed(32'h8000_0000, 1'b0);
    feed(32'h0000_0001, 1'b0);

    last = '0;
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          hi = llf_pkg::LEAD_MAX_RESET;
          lo = llf_pkg::LEAD_MIN_RESET;
        end
        1: begin
          width = $urandom_range(0, 1 << 24);
          hi = width;
          lo = -width;
        end
        2: begin
          // crossed
          width = $urandom_range(1, 1 << 20);
          hi = -width;
          lo = width;
        end
        default: begin
          hi = $urandom;
          lo = $urandom;
        end
      endcase
      // the last phase goes back to the defaults
      if (ph == PHASE_COUNT - 1)
        apply_config(CW'(llf_pkg::COEF_LAG_RESET), llf_pkg::COEF_LEAD_RESET,
                     llf_pkg::LEAD_MAX_RESET, llf_pkg::LEAD_MIN_RESET);
      else
        apply_config(pick_lag(), pick_lead(), hi, lo);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        restart = (n == 0) || ($urandom_range(0, 19) == 0);
        last = pick_sample(last);
        feed(last, restart);
      end
    end

    wait_idle();
    while (sb.pending() != 0) begin
      void'(sb.expected_results.pop_front());
      sb.report("expected result never arrived");
    end

    if (sb.errors == 0) begin
      $display("PASS exponential_lead_lag_filter_core");
    end else begin
      $display("FAIL exponential_lead_lag_filter_core");
    end
    $finish;
  end

endmodule
